/* design/assert_macros.svh */
// Assertion macros used by the top level of the radix digit converter.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define ITRD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define ITRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/itrd_pkg.sv */
// Package for the integer to radix digit converter: widths, constants,
// the sequencer state type and the digit to ASCII mapping. No dependencies.
`default_nettype none

package itrd_pkg;

    localparam int VALUE_W            = 32;
    localparam int RADIX_W            = 6;
    localparam int DIGIT_W            = 6;
    localparam int CHAR_W             = 7;
    localparam int VALUE_BITS_DEFAULT = 32;

    // Quotient bits retired by the shared divide unit in one cycle.
    localparam int STEP_BITS = 8;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0]  ASCII_LOWER_A = 7'h61;
    localparam logic [DIGIT_W-1:0] DECIMAL_TEN   = 6'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    // Digits 0 to 9 map to '0'-'9', digits 10 to 35 map to 'a'-'z'.
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DECIMAL_TEN)
        begin
            c = ASCII_ZERO + CHAR_W'(d);
        end
        else
        begin
            c = ASCII_LOWER_A + CHAR_W'(d - DECIMAL_TEN);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* design/itrd_if.sv */
// Valid/ready stream interfaces for the input value and the output digits.
// Depends on itrd_pkg for the payload widths.
`default_nettype none

interface itrd_in_if;
    logic                          valid;
    logic                          ready;
    logic [itrd_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface itrd_out_if;
    logic                          valid;
    logic                          ready;
    logic [itrd_pkg::CHAR_W-1:0]   digit_char;
    logic                          last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

`default_nettype wire

/* design/integer_to_radix_digits_top.sv */
// Top level of the integer to radix digit converter.
// Depends on itrd_pkg, itrd_if (itrd_in_if, itrd_out_if), itrd_ram and assert_macros.svh.
//
//   Channel   Direction  Payload                          Handshake
//   -------   ---------  -------------------------------  ----------------------
//   din       in         value (32 bits, unsigned)        din.valid / din.ready
//   dout      out        digit_char (7), last_digit (1)   dout.valid / dout.ready
//   cfg       in         cfg_wdata = radix (6 bits)       cfg_we, no wait
//
// A value is accepted in ST_IDLE; each digit that needs a division then takes an
// ST_CHECK step and NCH passes, where NCH = ceil(DATA_BITS / 8) is the number of
// passes through the shared 8-bit divide unit; the leading digit is written from
// ST_CHECK, and every digit is then read back and emitted in ST_EMIT.
// Reset (rst_n, asynchronous, active low) sets the radix to ten and idles the
// sequencer; the digit store needs no clearing. A stalled dout holds the current
// digit and pauses the store reads; din is ready only while the sequencer is idle.
`default_nettype none
`include "assert_macros.svh"

module integer_to_radix_digits_top #(
    parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [itrd_pkg::RADIX_W-1:0] cfg_wdata,
    itrd_in_if.sink                           din,
    itrd_out_if.source                        dout
);

    // Only the low VALUE_BITS of the value are converted. The widest value
    // determines the largest digit count, which is one digit per bit in radix two.
    localparam int DATA_BITS = (VALUE_BITS < itrd_pkg::VALUE_W) ? VALUE_BITS
                                                                 : itrd_pkg::VALUE_W;
    localparam int DEPTH     = DATA_BITS;
    localparam int AW        = $clog2(DEPTH);
    localparam int CW        = $clog2(DEPTH + 1);
    localparam int STEP      = itrd_pkg::STEP_BITS;
    localparam int NCH       = (DATA_BITS + STEP - 1) / STEP;
    localparam int QW        = NCH * STEP;
    localparam int CCW       = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int DW        = itrd_pkg::DIGIT_W;

    // Registers.
    itrd_pkg::state_t              state_reg, state_next;
    logic [itrd_pkg::RADIX_W-1:0]  radix_reg;
    logic [QW-1:0]                 q_reg, q_next;
    logic [DW-1:0]                 rem_reg, rem_next;
    logic [CW-1:0]                 n_reg, n_next;
    logic [CCW-1:0]                chunk_reg, chunk_next;
    logic [AW-1:0]                 addr_reg, addr_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          last_reg, last_next;

    // Digit store and divide unit signals.
    logic                          wr_en;
    logic [DW-1:0]                 wr_data;
    logic                          rd_en;
    logic [DW-1:0]                 rd_data;
    logic [itrd_pkg::RADIX_W-1:0]  radix_eff;
    logic [QW-1:0]                 q_div;
    logic [DW-1:0]                 rem_div;

    // Radix values outside two to thirty-six are clamped to the nearest end.
    always_comb
    begin
        if (radix_reg < itrd_pkg::RADIX_MIN)
        begin
            radix_eff = itrd_pkg::RADIX_MIN;
        end
        else if (radix_reg > itrd_pkg::RADIX_MAX)
        begin
            radix_eff = itrd_pkg::RADIX_MAX;
        end
        else
        begin
            radix_eff = radix_reg;
        end
    end

    // Shared divide unit: restoring long division of the top STEP quotient bits
    // by the radix. The partial remainder stays below the radix, so each trial is
    // a 7-bit compare and subtract. Each pass shifts the quotient register left by
    // STEP bits and fills in the new bits, so NCH passes give the full new quotient.
    always_comb
    begin : div_unit
        logic [DW:0]       trial;
        logic [DW-1:0]     rem;
        logic [STEP-1:0]   qbits;
        rem   = rem_reg;
        qbits = '0;
        for (int i = STEP - 1; i >= 0; i--)
        begin
            trial = {rem, q_reg[QW - STEP + i]};
            if (trial >= {1'b0, radix_eff})
            begin
                rem      = DW'(trial - {1'b0, radix_eff});
                qbits[i] = 1'b1;
            end
            else
            begin
                rem = trial[DW-1:0];
            end
        end
        rem_div = rem;
        q_div   = (q_reg << STEP) | QW'(qbits);
    end

    // Sequencer: next state and control.
    always_comb
    begin
        state_next     = state_reg;
        q_next         = q_reg;
        rem_next       = rem_reg;
        n_next         = n_reg;
        chunk_next     = chunk_reg;
        addr_next      = addr_reg;
        last_next      = last_reg;
        wr_en          = 1'b0;
        wr_data        = rem_div;
        rd_en          = 1'b0;
        din.ready      = 1'b0;

        case (state_reg)
            itrd_pkg::ST_IDLE:
            begin
                din.ready = 1'b1;
                if (din.valid)
                begin
                    q_next     = QW'(din.value[DATA_BITS-1:0]);
                    n_next     = '0;
                    state_next = itrd_pkg::ST_CHECK;
                end
            end

            itrd_pkg::ST_CHECK:
            begin
                if (q_reg >= QW'(radix_eff))
                begin
                    rem_next   = '0;
                    chunk_next = '0;
                    state_next = itrd_pkg::ST_DIVIDE;
                end
                else
                begin
                    // The remaining quotient is the most significant digit.
                    wr_en      = 1'b1;
                    wr_data    = q_reg[DW-1:0];
                    addr_next  = n_reg[AW-1:0];
                    state_next = itrd_pkg::ST_EMIT;
                end
            end

            itrd_pkg::ST_DIVIDE:
            begin
                q_next     = q_div;
                rem_next   = rem_div;
                chunk_next = chunk_reg + 1'b1;
                if (chunk_reg == CCW'(NCH - 1))
                begin
                    wr_en      = 1'b1;
                    n_next     = n_reg + 1'b1;
                    state_next = itrd_pkg::ST_CHECK;
                end
            end

            itrd_pkg::ST_EMIT:
            begin
                // Digits are read back from the most significant one down.
                if (!out_valid_reg || dout.ready)
                begin
                    rd_en     = 1'b1;
                    addr_next = addr_reg - 1'b1;
                    last_next = (addr_reg == '0);
                    if (addr_reg == '0)
                    begin
                        state_next = itrd_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = itrd_pkg::ST_IDLE;
            end
        endcase

        if (rd_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= itrd_pkg::ST_IDLE;
            radix_reg     <= itrd_pkg::RADIX_RESET;
            n_reg         <= '0;
            chunk_reg     <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            chunk_reg     <= chunk_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
            if (cfg_we)
            begin
                radix_reg <= cfg_wdata;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    // Digit store, least significant digit at address zero.
    itrd_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_digit_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (n_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    // The store's read register doubles as the output data register.
    assign dout.valid      = out_valid_reg;
    assign dout.digit_char = itrd_pkg::digit_to_ascii(rd_data);
    assign dout.last_digit = last_reg;

    // The store is read only while digits are being emitted.
    `ITRD_ASSERT_IMPL(a_read_in_emit, rd_en, state_reg == itrd_pkg::ST_EMIT,
        "digit store read outside the emit phase")

    // The digit count never runs past the store while digits are produced.
    `ITRD_ASSERT_IMPL(a_count_in_range,
        state_reg == itrd_pkg::ST_CHECK || state_reg == itrd_pkg::ST_DIVIDE,
        n_reg < CW'(DEPTH), "digit count overran the digit store")

    // Writing the leading digit always hands over to the emit phase.
    `ITRD_ASSERT_NEXT(a_lead_then_emit, wr_en && state_reg == itrd_pkg::ST_CHECK,
        state_reg == itrd_pkg::ST_EMIT, "leading digit not followed by emit")

endmodule

`default_nettype wire

/* design/itrd_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module itrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* sim/integer_to_radix_digits_top_test.sv */
// Self-checking testbench for integer_to_radix_digits_top: directed and random values
// are converted under many radix settings and every digit transaction is checked.
// Depends on itrd_pkg, itrd_in_if, itrd_out_if and the design files.
`timescale 1ns / 1ps

module integer_to_radix_digits_top_test;

    // Widths taken from the package.
    localparam int VALUE_W = itrd_pkg::VALUE_W;
    localparam int RADIX_W = itrd_pkg::RADIX_W;
    localparam int DIGIT_W = itrd_pkg::DIGIT_W;
    localparam int CHAR_W  = itrd_pkg::CHAR_W;

    // Clock period is 8 ns. The cycle limit covers the slowest correct run several
    // times over: every value giving 32 digits, each digit held off by the longest gap,
    // each value preceded by the longest gap, plus the long output stall.
    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int HOLD_CYCLES = 300;
    localparam int END_WAIT    = 200;
    localparam int MAX_GAP     = 10;
    localparam int PRINT_LIMIT = 20;

    // One expected output transaction: the ASCII digit and its last flag.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } digit_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [RADIX_W-1:0] cfg_wdata;

    itrd_in_if  din_bus ();
    itrd_out_if dout_bus ();

    integer_to_radix_digits_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .din       (din_bus),
        .dout      (dout_bus)
    );

    // Digits still owed by the block, oldest first.
    digit_t             pending_digits[$];
    // The testbench's copy of the radix register.
    logic [RADIX_W-1:0] cur_radix;

    int  mismatch_count;
    int  values_sent;
    int  digits_seen;
    int  radix_writes;
    int  cycle_count;
    int  hold_left;
    bit  hold_request;
    bit  no_idle;

    // ------------------------------------------------------------------
    // Clock and watchdog.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // The watchdog counts rising edges and ends a run that hangs.
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d digits still pending",
                 cycle_count, pending_digits.size());
        $display("[integer_to_radix_digits_top] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction.
    // ------------------------------------------------------------------

    // Radix values below two act as two and values above thirty-six act as thirty-six.
    function automatic logic [RADIX_W-1:0] effective_base(input logic [RADIX_W-1:0] r);
        if (r < itrd_pkg::RADIX_MIN)
        begin
            return itrd_pkg::RADIX_MIN;
        end
        if (r > itrd_pkg::RADIX_MAX)
        begin
            return itrd_pkg::RADIX_MAX;
        end
        return r;
    endfunction

    // Converts one accepted value under the current radix and queues its digits,
    // most significant first. The division loop runs while the quotient is at
    // least the base, so a value equal to the base gives "10", and zero gives
    // the single digit '0'.
    function automatic void predict_digits(input logic [VALUE_W-1:0] v);
        logic [RADIX_W-1:0] base;
        logic [VALUE_W-1:0] q;
        logic [DIGIT_W-1:0] digs [VALUE_W];
        logic [DIGIT_W-1:0] dv;
        digit_t             d;
        int                 n;
        base = effective_base(cur_radix);
        q    = v;
        n    = 0;
        while (q >= base && n < VALUE_W - 1)
        begin
            digs[n] = DIGIT_W'(q % base);
            q       = q / base;
            n++;
        end
        digs[n] = q[DIGIT_W-1:0];
        n++;
        for (int k = 0; k < n; k++)
        begin
            dv = digs[n - 1 - k];
            if (dv < 10)
            begin
                d.ch = itrd_pkg::ASCII_ZERO + CHAR_W'(dv);
            end
            else
            begin
                d.ch = itrd_pkg::ASCII_LOWER_A + CHAR_W'(dv - 10);
            end
            d.last = (k == n - 1);
            pending_digits.push_back(d);
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking.
    // ------------------------------------------------------------------

    // Prints one line per mismatch, up to a limit, and counts them all.
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
        begin
            $display("mismatch at cycle %0d: %s, got %0d, expected %0d",
                     cycle_count, what, got, want);
        end
    endtask

    // Every output transaction is compared with the oldest pending digit.
    // Outputs are sampled at the rising edge, while the testbench drives on the
    // falling edge, so the sampled values are stable.
    always @(posedge clk)
    begin : digit_checker
        digit_t want_digit;
        if (rst_n && dout_bus.valid && dout_bus.ready)
        begin
            digits_seen++;
            if (pending_digits.size() == 0)
            begin
                report_mismatch("digit with nothing pending", dout_bus.digit_char, 0);
            end
            else
            begin
                want_digit = pending_digits.pop_front();
                if (dout_bus.digit_char !== want_digit.ch)
                begin
                    report_mismatch("digit_char", dout_bus.digit_char, want_digit.ch);
                end
                if (dout_bus.last_digit !== want_digit.last)
                begin
                    report_mismatch("last_digit", dout_bus.last_digit, want_digit.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: random ready gaps and the long hold-off.
    // ------------------------------------------------------------------

    // The hold-off counter runs in its own process. A test raises hold_request,
    // and the counter then loads HOLD_CYCLES and keeps ready low until it runs out.
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
        end
    end

    // After each output transaction the receiver draws how many cycles it waits
    // before it takes the next digit. Ready gets exactly one assignment per
    // falling edge, so a zero wait leaves it high without a glitch.
    initial
    begin : receiver
        int rx_wait;
        int rx_seen;
        rx_wait        = 0;
        rx_seen        = 0;
        dout_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (digits_seen != rx_seen)
            begin
                rx_seen = digits_seen;
                rx_wait = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (!rst_n || hold_left > 0)
            begin
                dout_bus.ready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                dout_bus.ready <= 1'b0;
                rx_wait--;
            end
            else
            begin
                dout_bus.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------

    // Offers one value after a random gap and waits for its transaction. The task
    // is entered and left at a falling edge. Valid stays high on exit, so a gap
    // of zero keeps it high into the next value; a gap lowers it first.
    task automatic send_value(input logic [VALUE_W-1:0] v);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            din_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        din_bus.valid <= 1'b1;
        din_bus.value <= v;
        do
        begin
            @(posedge clk);
        end
        while (!din_bus.ready);
        predict_digits(v);
        values_sent++;
        @(negedge clk);
    endtask

    // Lowers valid and waits until every pending digit has come out; the block
    // is idle afterwards, since each value ends with its last digit.
    task automatic drain();
        din_bus.valid <= 1'b0;
        while (pending_digits.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(negedge clk);
    endtask

    // Writes the radix register. Only called while the block is idle.
    task automatic write_radix(input logic [RADIX_W-1:0] r);
        cfg_we    <= 1'b1;
        cfg_wdata <= r;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_radix  = r;
        radix_writes++;
    endtask

    // Random values: full words, values near the base, powers of the base and
    // their neighbors, short words, and words near all zeros or all ones.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [63:0]        p;
        logic [RADIX_W-1:0] base;
        int                 k;
        base = effective_base(cur_radix);
        case ($urandom_range(0, 4))
            0:
            begin
                return $urandom;
            end
            1:
            begin
                return $urandom_range(0, 2 * base + 1);
            end
            2:
            begin
                p = 1;
                k = $urandom_range(1, 31);
                repeat (k)
                begin
                    if (p * base <= 64'hFFFF_FFFF)
                    begin
                        p = p * base;
                    end
                end
                return VALUE_W'(p + $urandom_range(0, 2) - 1);
            end
            3:
            begin
                return $urandom >> $urandom_range(0, 31);
            end
            default:
            begin
                return ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0)
                       ^ (32'h1 << $urandom_range(0, 31));
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // The radix comes out of reset as ten; no write is made here. A value equal
    // to the base must give "10" and zero must give a single '0'.
    task automatic test_reset_radix();
        send_value(32'd0);
        send_value(32'd9);
        send_value(32'd10);
        send_value(32'd11);
        send_value(32'd1);
        send_value(32'hFFFF_FFFF);
        drain();
    endtask

    // Base two gives the longest strings: 32 digits for the top values.
    task automatic test_binary();
        write_radix(6'd2);
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'd2);
        send_value(32'd3);
        send_value(32'h8000_0000);
        send_value(32'hFFFF_FFFF);
        drain();
    endtask

    // Base thirty-six reaches the letter 'z'.
    task automatic test_base36();
        write_radix(6'd36);
        send_value(32'd35);
        send_value(32'd36);
        send_value(32'd37);
        send_value(32'hFFFF_FFFF);
        drain();
    endtask

    task automatic test_hex();
        write_radix(6'd16);
        send_value(32'hDEAD_BEEF);
        send_value(32'd15);
        send_value(32'd16);
        drain();
    endtask

    // Radix settings outside two to thirty-six are clamped to the nearest end.
    task automatic test_clamped_radix();
        write_radix(6'd0);
        send_value(32'd5);
        drain();
        write_radix(6'd1);
        send_value(32'd2);
        drain();
        write_radix(6'd37);
        send_value(32'd36);
        drain();
        write_radix(6'd63);
        send_value(32'hFFFF_FFFF);
        send_value(32'd1295);
        drain();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // values, so the block stays busy with a value and must hold its input ready low.
    task automatic test_output_stall();
        write_radix(6'd10);
        hold_request = 1'b1;
        repeat (8) send_value(pick_value());
        drain();
    endtask

    task automatic test_random_values(input logic [RADIX_W-1:0] r, input int count);
        write_radix(r);
        repeat (count) send_value(pick_value());
        drain();
    endtask

    // Both sides run without gaps: values follow each other back to back.
    task automatic test_back_to_back();
        write_radix(6'd8);
        no_idle = 1'b1;
        repeat (30) send_value(pick_value());
        drain();
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        din_bus.valid  = 1'b0;
        din_bus.value  = '0;
        cur_radix      = itrd_pkg::RADIX_RESET;
        mismatch_count = 0;
        values_sent    = 0;
        digits_seen    = 0;
        radix_writes   = 0;
        hold_left      = 0;
        hold_request   = 1'b0;
        no_idle        = 1'b0;

        // Reset is held low from the start and released on a falling edge.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_reset_radix();
        test_binary();
        test_base36();
        test_hex();
        test_clamped_radix();
        test_output_stall();

        test_random_values(6'd10, 40);
        test_random_values(6'd2, 40);
        test_random_values(6'd36, 40);
        test_random_values(6'd16, 40);
        test_random_values(6'd0, 30);
        test_random_values(6'd63, 30);
        test_random_values(6'd7, 40);
        for (int i = 0; i < 4; i++)
        begin
            test_random_values(RADIX_W'($urandom_range(0, 63)), 35);
        end
        test_back_to_back();

        // Any stray digit after the last expected one is caught by the checker.
        repeat (END_WAIT) @(posedge clk);

        $display("Converted %0d values into %0d digits under %0d radix writes,",
                 values_sent, digits_seen, radix_writes);
        $display("with clamped radix settings, a long output stall and gapless runs.");
        if (mismatch_count == 0 && pending_digits.size() == 0)
        begin
            $display("[integer_to_radix_digits_top] OK");
        end
        else
        begin
            $display("%0d mismatches, %0d digits never seen",
                     mismatch_count, pending_digits.size());
            $display("[integer_to_radix_digits_top] ERROR");
        end
        $finish;
    end

endmodule
